// File: sv/svlq_pkg.sv
// Package for the signed VLQ sample encoder: widths, digit constants,
// FSM state type and the load bundle passed to the digit shifter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svlq_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DigitW    = 7;
  localparam int unsigned NumDigits = 3;
  localparam int unsigned ShiftW    = DigitW * NumDigits;
  localparam int unsigned FirstW    = 6;
  localparam int unsigned CntW      = 2;

  localparam logic [SampleW-1:0] OneOctetMax = 16'd63;
  localparam logic [SampleW-1:0] TwoOctetMax = 16'd8191;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_NEXT
  } svlq_state_e;

  typedef struct packed {
    logic               sign;
    logic [SampleW-1:0] mag;
    logic [CntW-1:0]    extra;
  } svlq_load_t;

endpackage
`default_nettype wire

// File: sv/svlq_mag_len.sv
// Sign, magnitude and extra-octet count of one sample.
// Depends on svlq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svlq_mag_len (
  input  wire logic signed [svlq_pkg::SampleW-1:0] sample_i,
  output svlq_pkg::svlq_load_t                     load_o
);
  import svlq_pkg::*;

  logic [SampleW-1:0] raw;
  logic [SampleW-1:0] mag;

  assign raw = sample_i;
  assign mag = raw[SampleW-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    load_o.sign = raw[SampleW-1];
    load_o.mag  = mag;
    if (mag <= OneOctetMax) begin
      load_o.extra = 2'd0;
    end else if (mag <= TwoOctetMax) begin
      load_o.extra = 2'd1;
    end else begin
      load_o.extra = 2'd2;
    end
  end

endmodule
`default_nettype wire

// File: sv/svlq_digit_shift.sv
// Digit shift register: loads the magnitude left-aligned to its first digit,
// then shifts out one 7-bit digit per cycle while shift_i is high. Depends on svlq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svlq_digit_shift (
  input  wire logic                       clk_i,
  input  wire logic                       load_i,
  input  wire logic                       shift_i,
  input  wire svlq_pkg::svlq_load_t       load_data_i,
  output logic [svlq_pkg::DigitW-1:0]     digit_o
);
  import svlq_pkg::*;

  logic [ShiftW-1:0] sr_q, sr_d;
  logic [ShiftW-1:0] base;

  assign base = {{(ShiftW-SampleW){1'b0}}, load_data_i.mag};

  always_comb begin
    sr_d = sr_q;
    if (load_i) begin
      case (load_data_i.extra)
        2'd0:    sr_d = base << (2 * DigitW);
        2'd1:    sr_d = base << DigitW;
        default: sr_d = base;
      endcase
    end else if (shift_i) begin
      sr_d = sr_q << DigitW;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign digit_o = sr_q[ShiftW-1 -: DigitW];

endmodule
`default_nettype wire

// File: sv/signed_vlq_sample_encoder_top.sv
// Top level of the signed VLQ sample encoder: stream ports, sequencer FSM
// and output register. Depends on svlq_pkg, svlq_mag_len, svlq_digit_shift.
// Order: a sample transfer loads the digit shifter, then the first octet is registered
// in the output register. Throughput: one octet per cycle unless the output stalls,
// so a sample yields 1 to 3 octets; the digit shifter emits one digit per cycle
// unless stalled, and the next sample loads in the cycle its last octet leaves.
// Reset: rst_ni clears the FSM, octet counter and output valid; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module signed_vlq_sample_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample (signed)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] code_byte
  output logic             m_axis_tlast    // last_byte
);
  import svlq_pkg::*;

  svlq_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              sign_q, sign_d;
  logic              m_valid_q, m_valid_d;
  logic [ByteW-1:0]  m_data_q, m_data_d;
  logic              m_last_q, m_last_d;

  svlq_load_t        ld;
  logic [DigitW-1:0] digit;
  logic              move, load, first, more;

  svlq_mag_len u_mag_len (
    .sample_i (s_axis_tdata),
    .load_o   (ld)
  );

  svlq_digit_shift u_digit_shift (
    .clk_i       (clk_i),
    .load_i      (load),
    .shift_i     (move),
    .load_data_i (ld),
    .digit_o     (digit)
  );

  // FSM outputs
  always_comb begin
    move          = 1'b0;
    first         = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_FIRST: begin
        first         = 1'b1;
        move          = !m_valid_q || m_axis_tready;
        s_axis_tready = move && (cnt_q == 2'd1);
      end
      ST_NEXT: begin
        move          = !m_valid_q || m_axis_tready;
        s_axis_tready = move && (cnt_q == 2'd1);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign load = s_axis_tvalid && s_axis_tready;
  assign more = cnt_q > 2'd1;

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load) state_d = ST_FIRST;
      end
      ST_FIRST, ST_NEXT: begin
        if (load) begin
          state_d = ST_FIRST;
        end else if (move && !more) begin
          state_d = ST_IDLE;
        end else if (move) begin
          state_d = ST_NEXT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    sign_d    = sign_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (m_axis_tready) m_valid_d = 1'b0;
    if (move) begin
      m_valid_d = 1'b1;
      m_last_d  = !more;
      cnt_d     = cnt_q - 1'b1;
      if (first) begin
        m_data_d = {more, sign_q, digit[FirstW-1:0]};
      end else begin
        m_data_d = {more, digit};
      end
    end
    if (load) begin
      cnt_d  = ld.extra + 1'b1;
      sign_d = ld.sign;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q   <= sign_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire
